// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the filter block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent, off during reset.
`define LHP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lhp assertion failed");

// Consequent checked in the cycle after the antecedent, off while rst is high.
`define LHP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lhp assertion failed");

`endif

// ===== hw/rtl/lhp_pkg.sv =====
// ----------------------------------------------------------------------------
// lhp_pkg
// Types and constants of the 3x3 Laplacian high-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lhp_pkg;

   localparam int PIX_W      = 8;
   localparam int FWIDTH_W   = 11;
   localparam int FHEIGHT_W  = 12;
   localparam int ROW_W      = FHEIGHT_W + 1;
   localparam int MIN_DIM    = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_SEL_BIT = 2;

   localparam logic [FWIDTH_W-1:0]  WIDTH_RESET  = 11'd512;
   localparam logic [FHEIGHT_W-1:0] HEIGHT_RESET = 12'd512;
   localparam logic [PIX_W-1:0]     PIX_MAX      = '1;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_DRAIN = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [FWIDTH_W-1:0]  frame_width;
      logic [FHEIGHT_W-1:0] frame_height;
      logic                 restart;
   } frame_cfg_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic left_ok;
      logic right_ok;
      logic top_ok;
      logic bottom_ok;
   } tap_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lhp_req_if.sv =====
// ----------------------------------------------------------------------------
// lhp_req_if
// Input item channel: pixel or drain step, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lhp_req_if;
   import lhp_pkg::*;

   logic             valid;
   logic             ready;
   logic             req_type;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output req_type, output pixel_in, input ready);
   modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lhp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lhp_rsp_if
// Result item channel: filtered pixel and end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lhp_rsp_if;
   import lhp_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             last_of_frame;

   modport source (output valid, output pixel_out, output last_of_frame, input ready);
   modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lhp_csr.sv =====
// ----------------------------------------------------------------------------
// lhp_csr
// APB register file holding the frame width and height.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lhp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lhp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lhp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output lhp_pkg::frame_cfg_type            cfg
);
   import lhp_pkg::*;

   logic                 wr_en;
   csr_reg_type          sel;
   logic [FWIDTH_W-1:0]  width_ff;
   logic [FHEIGHT_W-1:0] height_ff;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign sel    = csr_reg_type'(paddr[CSR_SEL_BIT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (wr_en) begin
         unique case (sel)
            REG_FRAME_WIDTH:  width_ff  <= pwdata[FWIDTH_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= pwdata[FHEIGHT_W-1:0];
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_FRAME_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:          prdata = '0;
      endcase
   end

   // Every register write starts a new frame.
   assign cfg.frame_width  = width_ff;
   assign cfg.frame_height = height_ff;
   assign cfg.restart      = wr_en;

endmodule

`default_nettype wire

// ===== hw/rtl/lhp_line_mem.sv =====
// ----------------------------------------------------------------------------
// lhp_line_mem
// Line buffer RAM: each entry holds the upper and middle row pixel of a column.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_line_mem #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
   output logic [2*lhp_pkg::PIX_W-1:0]     rd_data,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
   input  logic [2*lhp_pkg::PIX_W-1:0]     wr_data
);
   import lhp_pkg::*;

   logic [2*PIX_W-1:0] line_ram [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ram[wr_addr] <= wr_data;
      end
   end

   // Read data holds between reads so a stalled item keeps its column.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lhp_ctrl
// Raster position counters, edge flags and the line buffer read stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_ctrl #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lhp_pkg::frame_cfg_type          cfg,
   lhp_req_if.sink                         req,
   input  logic                            stage_b_ready,
   output logic                            a_valid,
   output logic [lhp_pkg::PIX_W-1:0]       a_pix,
   output logic [$clog2(MAX_WIDTH)-1:0]    a_idx,
   output lhp_pkg::tap_ctl_type            a_ctl,
   output logic                            rd_en,
   output logic [$clog2(MAX_WIDTH)-1:0]    rd_addr
);
   import lhp_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int EW = (AW + 1 > FWIDTH_W) ? AW + 1 : FWIDTH_W;

   logic [AW-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 a_valid_ff, a_valid_in;
   logic [PIX_W-1:0]     a_pix_ff;
   logic [AW-1:0]        a_idx_ff;
   tap_ctl_type          a_ctl_ff, ctl;

   logic [EW-1:0]        width_ext, width_eff;
   logic [AW-1:0]        col_last;
   logic [FHEIGHT_W-1:0] height_eff;
   logic [ROW_W-1:0]     h_ext;
   logic                 accept, a_take, col_zero, col_ge2, emit_right, emit_mid, drain;
   logic [PIX_W-1:0]     pix;

   always_comb begin
      width_ext = EW'(cfg.frame_width);
      priority if (width_ext < EW'(MIN_DIM)) begin
         width_eff = EW'(MIN_DIM);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         width_eff = EW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      col_last = AW'(width_eff - EW'(1));
      height_eff = (cfg.frame_height < FHEIGHT_W'(MIN_DIM)) ?
                   FHEIGHT_W'(MIN_DIM) : cfg.frame_height;
      h_ext = ROW_W'(height_eff);
   end

   assign req.ready = !a_valid_ff || stage_b_ready;
   assign accept    = req.valid && req.ready;
   assign a_take    = a_valid_ff && stage_b_ready;

   // The window is shifted before the taps are taken, so the last pixel of
   // the previous row (emitted on column zero) sits in the centre column.
   always_comb begin
      col_zero   = (col_ff == '0);
      col_ge2    = (EW'(col_ff) >= EW'(MIN_DIM));
      emit_right = col_zero && (row_ff >= ROW_W'(2)) && (row_ff <= h_ext + ROW_W'(1));
      emit_mid   = !col_zero && (row_ff >= ROW_W'(1)) && (row_ff <= h_ext);
      ctl.emit      = emit_right || emit_mid;
      ctl.last      = emit_right && (row_ff == h_ext + ROW_W'(1));
      ctl.left_ok   = col_zero || col_ge2;
      ctl.right_ok  = !col_zero;
      ctl.top_ok    = col_zero ? (row_ff >= ROW_W'(3)) : (row_ff >= ROW_W'(2));
      ctl.bottom_ok = col_zero ? (row_ff <= h_ext) : (row_ff < h_ext);
      drain = (req.req_type == REQ_DRAIN) || (row_ff >= h_ext);
      pix   = drain ? '0 : req.pixel_in;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept && ctl.last) begin
         col_in = '0;
         row_in = '0;
      end else if (accept && (col_ff == col_last)) begin
         col_in = '0;
         row_in = row_ff + ROW_W'(1);
      end else if (accept) begin
         col_in = col_ff + AW'(1);
      end
   end

   always_comb begin
      priority if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_take) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff <= pix;
         a_idx_ff <= col_ff;
         a_ctl_ff <= ctl;
      end
   end

   assign a_valid = a_valid_ff;
   assign a_pix   = a_pix_ff;
   assign a_idx   = a_idx_ff;
   assign a_ctl   = a_ctl_ff;
   assign rd_en   = accept;
   assign rd_addr = col_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lhp_window.sv =====
// ----------------------------------------------------------------------------
// lhp_window
// 3x3 window, line buffer write-back, masked Laplacian and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_window (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            a_valid,
   input  logic [lhp_pkg::PIX_W-1:0]       a_pix,
   input  lhp_pkg::tap_ctl_type            a_ctl,
   input  logic [2*lhp_pkg::PIX_W-1:0]     rd_data,
   output logic                            stage_b_ready,
   output logic                            wr_en,
   output logic [2*lhp_pkg::PIX_W-1:0]     wr_data,
   lhp_rsp_if.source                       rsp
);
   import lhp_pkg::*;

   localparam int SUM_W  = PIX_W + 3;
   localparam int CNT_W  = 4;
   localparam int PROD_W = PIX_W + CNT_W;
   localparam int DIFF_W = PROD_W + 1;

   logic [PIX_W-1:0]  win_ff [3][3];
   logic              b_valid_ff, b_valid_in;
   tap_ctl_type       b_ctl_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pix_ff, rsp_pix_in;
   logic              rsp_last_ff;

   logic [PIX_W-1:0]  up_pix, mid_pix;
   logic              out_free, a_take, b_fire;
   logic [PIX_W-1:0]  nb_val [8];
   logic [7:0]        nb_use;
   logic [SUM_W-1:0]  nb_sum;
   logic [CNT_W-1:0]  nb_cnt;
   logic [PROD_W-1:0] centre_prod;
   logic [DIFF_W-1:0] diff;

   assign up_pix  = rd_data[2*PIX_W-1:PIX_W];
   assign mid_pix = rd_data[PIX_W-1:0];

   assign out_free      = !rsp_valid_ff || rsp.ready;
   assign stage_b_ready = !b_valid_ff || !b_ctl_ff.emit || out_free;
   assign a_take        = a_valid && stage_b_ready;
   assign b_fire        = b_valid_ff && b_ctl_ff.emit && out_free;

   // Middle row moves up, the new pixel becomes the middle row.  The read of
   // the next item targets another column because rows are at least two
   // pixels wide, except for the first item after a frame ends; the stale
   // column-zero values it then sees only reach window positions that the
   // edge masks drop, so no forwarding is needed.
   assign wr_en   = a_take;
   assign wr_data = {mid_pix, a_pix};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (a_take) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= up_pix;
         win_ff[1][2] <= mid_pix;
         win_ff[2][2] <= a_pix;
      end
   end

   always_comb begin
      nb_val[0] = win_ff[0][0];
      nb_val[1] = win_ff[0][1];
      nb_val[2] = win_ff[0][2];
      nb_val[3] = win_ff[1][0];
      nb_val[4] = win_ff[1][2];
      nb_val[5] = win_ff[2][0];
      nb_val[6] = win_ff[2][1];
      nb_val[7] = win_ff[2][2];
      nb_use[0] = b_ctl_ff.top_ok && b_ctl_ff.left_ok;
      nb_use[1] = b_ctl_ff.top_ok;
      nb_use[2] = b_ctl_ff.top_ok && b_ctl_ff.right_ok;
      nb_use[3] = b_ctl_ff.left_ok;
      nb_use[4] = b_ctl_ff.right_ok;
      nb_use[5] = b_ctl_ff.bottom_ok && b_ctl_ff.left_ok;
      nb_use[6] = b_ctl_ff.bottom_ok;
      nb_use[7] = b_ctl_ff.bottom_ok && b_ctl_ff.right_ok;
      nb_sum = '0;
      for (int i = 0; i < 8; i++) begin
         if (nb_use[i]) begin
            nb_sum = nb_sum + SUM_W'(nb_val[i]);
         end
      end
      nb_cnt      = CNT_W'($countones(nb_use));
      centre_prod = PROD_W'(nb_cnt) * PROD_W'(win_ff[1][1]);
      diff        = DIFF_W'(centre_prod) - DIFF_W'(nb_sum);
      // Negative results show up as a set sign bit and clamp to zero.
      priority if (diff[DIFF_W-1]) begin
         rsp_pix_in = '0;
      end else if (diff > DIFF_W'(PIX_MAX)) begin
         rsp_pix_in = PIX_MAX;
      end else begin
         rsp_pix_in = diff[PIX_W-1:0];
      end
   end

   always_comb begin
      priority if (a_take) begin
         b_valid_in = 1'b1;
      end else if (stage_b_ready) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
      priority if (b_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         b_ctl_ff <= a_ctl;
      end
      if (b_fire) begin
         rsp_pix_ff  <= rsp_pix_in;
         rsp_last_ff <= b_ctl_ff.last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.pixel_out     = rsp_pix_ff;
   assign rsp.last_of_frame = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/laplacian_highpass_3x3_unit.sv =====
// Pipeline: an accepted item passes the line RAM read, the window shift and
// the output register before its result is offered.
// Throughput: one item per cycle; only a result stalled at the output holds
// the input back. The line RAM is read once per item and written once per item.
// Reset (synchronous, active high) clears counters, window and valid flags and
// sets width and height to 512; the line RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// laplacian_highpass_3x3_unit
// Streaming 3x3 Laplacian high-pass filter with APB frame size registers.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_highpass_3x3_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   lhp_req_if.sink                        req,
   lhp_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lhp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lhp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lhp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import lhp_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   frame_cfg_type       cfg;
   logic                stage_b_ready;
   logic                a_valid;
   logic [PIX_W-1:0]    a_pix;
   logic [AW-1:0]       a_idx;
   tap_ctl_type         a_ctl;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [2*PIX_W-1:0]  rd_data;
   logic                wr_en;
   logic [2*PIX_W-1:0]  wr_data;

   lhp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lhp_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req           (req),
      .stage_b_ready (stage_b_ready),
      .a_valid       (a_valid),
      .a_pix         (a_pix),
      .a_idx         (a_idx),
      .a_ctl         (a_ctl),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr)
   );

   lhp_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (a_idx),
      .wr_data (wr_data)
   );

   lhp_window u_window (
      .clock         (clock),
      .reset         (reset),
      .a_valid       (a_valid),
      .a_pix         (a_pix),
      .a_ctl         (a_ctl),
      .rd_data       (rd_data),
      .stage_b_ready (stage_b_ready),
      .wr_en         (wr_en),
      .wr_data       (wr_data),
      .rsp           (rsp)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/lhp_checker.sv =====
// ----------------------------------------------------------------------------
// lhp_checker
// Port-level checks of the filter block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lhp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [lhp_pkg::PIX_W-1:0]      rsp_pixel_out,
   input logic                           rsp_last_of_frame,
   input logic                           psel,
   input logic                           penable,
   input logic                           pwrite,
   input logic [lhp_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [lhp_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [lhp_pkg::CSR_DATA_W-1:0] prdata
);
   import lhp_pkg::*;

   // Reset empties the pipeline, so no result is offered right after it.
   `LHP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A stalled result keeps its value until taken.
   `LHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_last_of_frame))

   // A result offered after an empty output comes from an item that went in and
   // passed the input and window stages without stalling.
   `LHP_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid),
      $past(req_valid && req_ready, 3))

   // A written frame width reads back on the following cycle.
   `LHP_ASSERT_NOW(a_width_readback, clock, reset,
      (psel && penable && pwrite && (paddr[CSR_SEL_BIT] == REG_FRAME_WIDTH))
         ##1 (paddr[CSR_SEL_BIT] == REG_FRAME_WIDTH),
      prdata[FWIDTH_W-1:0] == $past(pwdata[FWIDTH_W-1:0]))

endmodule

bind laplacian_highpass_3x3_unit lhp_checker u_lhp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_pixel_out     (rsp.pixel_out),
   .rsp_last_of_frame (rsp.last_of_frame),
   .psel              (psel),
   .penable           (penable),
   .pwrite            (pwrite),
   .paddr             (paddr),
   .pwdata            (pwdata),
   .prdata            (prdata)
);

`default_nettype wire
